// File: hw/rtl/lfbs_pkg.sv
// shared types, codes and constants of the led frame buffer serializer
`timescale 1ns / 1ps

package lfbs_pkg;

    localparam int LED_COUNT_DEF = 32;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_EMIT  = 2'd2;

    localparam logic [31:0] WORD_START  = 32'h0000_0000;
    localparam logic [31:0] WORD_END    = 32'hFFFF_FFFF;
    localparam logic [7:0]  FULL_BRIGHT = 8'hFF;

    localparam int PIXEL_W = 24;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } s_payload_t;

    typedef struct packed {
        logic [31:0] frame_word;
        logic        last_word;
    } m_payload_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_CLEAR,
        OP_EMIT
    } op_t;

    // classified request as it waits in the queue
    typedef struct packed {
        op_t        op;
        logic [7:0] pixel_addr;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } queue_entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        WK_START,
        WK_PIXEL,
        WK_END
    } word_kind_t;

endpackage

// File: hw/rtl/led_frame_buffer_serializer_unit.sv
// top level of the led frame buffer serializer
`timescale 1ns / 1ps

// Frame buffer and frame encoder for a serial RGB LED strip.
// Input channel s_valid/s_ready/s_payload carries requests: cmd 0 writes one pixel
// (index clamped to 1..LED_COUNT), cmd 1 clears all pixels, cmd 2 emits a frame,
// cmd 3 is taken and dropped. Output channel m_valid/m_ready/m_payload carries the
// frame words: a zero start word, one {0xff, blue, green, red} word per pixel and
// an all-ones end word with last_word set.
// Requests land in a two-entry queue; while no frame streams, the back end takes one
// write or clear per cycle, so pixel writes sustain one per cycle. An emit request
// streams LED_COUNT + 2 words at one per cycle while m_ready stays high, paced by the
// single read port of the pixel store; the first word passes the queue, the emit state,
// the read stage and the output register before it shows on m_valid. While a frame is
// streaming, later requests wait in the queue and s_ready drops once the queue is full.
// Reset (aresetn low, synchronous) empties the queue and the output register and
// marks every pixel as zero through per-pixel valid bits; no clearing pass is run.
// When the receiver stalls, the output register and a read stage hold their words
// and the frame resumes without loss.

module led_frame_buffer_serializer_unit import lfbs_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  s_payload_t s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output m_payload_t m_payload
);

    logic         q_valid;
    queue_entry_t q_head;
    logic         q_pop;

    lfbs_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    lfbs_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: hw/rtl/lfbs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lfbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lfbs_front.sv
// front end: accepts requests, classifies them and queues them for the back end
`timescale 1ns / 1ps

module lfbs_front import lfbs_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  s_payload_t   s_payload,
    output logic         q_valid,
    output queue_entry_t q_head,
    input  logic         q_pop
);

    queue_entry_t q_mem [2];
    logic [1:0]   count_reg, count_next;
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    queue_entry_t entry;
    logic         known;
    logic         push;

    // classify and clamp the one-based index to a zero-based address
    always_comb begin
        entry       = '0;
        known       = 1'b1;
        entry.red   = s_payload.red;
        entry.green = s_payload.green;
        entry.blue  = s_payload.blue;
        unique case (s_payload.cmd)
            CMD_WRITE: entry.op = OP_WRITE;
            CMD_CLEAR: entry.op = OP_CLEAR;
            CMD_EMIT:  entry.op = OP_EMIT;
            default: begin
                entry.op = OP_WRITE;
                known    = 1'b0;
            end
        endcase
        if (s_payload.pixel_index == 8'd0) begin
            entry.pixel_addr = 8'd0;
        end else if (s_payload.pixel_index > 8'(LED_COUNT)) begin
            entry.pixel_addr = 8'(LED_COUNT - 1);
        end else begin
            entry.pixel_addr = s_payload.pixel_index - 8'd1;
        end
    end

    assign s_ready = (count_reg != 2'd2);
    // the unused command is taken and dropped
    assign push    = s_valid && s_ready && known;
    assign q_valid = (count_reg != 2'd0);
    assign q_head  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

// File: hw/rtl/lfbs_back.sv
// back end: pixel store, clear and frame emission sequencer with output register
`timescale 1ns / 1ps

module lfbs_back import lfbs_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF,
    localparam int ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1,
    localparam int CNT_W  = $clog2(LED_COUNT + 2)
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    input  queue_entry_t q_head,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output m_payload_t   m_payload
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LED_COUNT + 1);

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LED_COUNT-1:0] valid_reg, valid_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  waddr;
    logic [PIXEL_W-1:0] wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  raddr;
    logic [PIXEL_W-1:0] rdata;
    logic               clr;
    logic               issue;
    word_kind_t         kind;

    logic       s1_valid_reg;
    word_kind_t s1_kind_reg;
    logic       s1_hit_reg;
    logic       out_ready;
    logic       s1_adv;
    logic       issue_ok;

    logic       m_valid_reg;
    m_payload_t m_payload_reg;
    m_payload_t word;

    lfbs_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (LED_COUNT)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_ready = !m_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign issue_ok  = !s1_valid_reg || out_ready;

    assign waddr = ADDR_W'(q_head.pixel_addr);
    assign wdata = {q_head.blue, q_head.green, q_head.red};
    assign raddr = ADDR_W'(cnt_reg - CNT_W'(1));

    always_comb begin
        if (cnt_reg == '0) begin
            kind = WK_START;
        end else if (cnt_reg == LAST_CNT) begin
            kind = WK_END;
        end else begin
            kind = WK_PIXEL;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_head.op == OP_EMIT) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (issue_ok && cnt_reg == LAST_CNT) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_pop  = 1'b0;
        ram_we = 1'b0;
        clr    = 1'b0;
        issue  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                q_pop  = q_valid;
                ram_we = q_valid && q_head.op == OP_WRITE;
                clr    = q_valid && q_head.op == OP_CLEAR;
            end
            ST_EMIT: begin
                issue = issue_ok;
            end
            default: ;
        endcase
    end

    assign ram_re = issue && kind == WK_PIXEL;

    always_comb begin
        cnt_next = cnt_reg;
        if (state_reg == ST_IDLE) begin
            cnt_next = '0;
        end else if (issue) begin
            // the end word wraps the counter back to the start
            cnt_next = (cnt_reg == LAST_CNT) ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    // an entry never written since reset or clear reads as zero
    always_comb begin
        valid_next = valid_reg;
        if (clr) begin
            valid_next = '0;
        end else if (ram_we) begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            if (issue) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_kind_reg <= kind;
            s1_hit_reg  <= valid_reg[raddr];
        end
        if (s1_adv) begin
            m_payload_reg <= word;
        end
    end

    always_comb begin
        word = '0;
        case (s1_kind_reg)
            WK_START: begin
                word.frame_word = WORD_START;
                word.last_word  = 1'b0;
            end
            WK_PIXEL: begin
                word.frame_word = s1_hit_reg ? {FULL_BRIGHT, rdata}
                                             : {FULL_BRIGHT, {PIXEL_W{1'b0}}};
                word.last_word  = 1'b0;
            end
            WK_END: begin
                word.frame_word = WORD_END;
                word.last_word  = 1'b1;
            end
            default: word = '0;
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef NO_ASSERTIONS
    a_no_pop_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> !q_pop && !ram_we && !clr)
        else $error("queue popped during frame emission");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LAST_CNT)
        else $error("word counter past end of frame");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_ready |=> s1_valid_reg && $stable(s1_kind_reg)
            && $stable(rdata))
        else $error("read stage lost its word under stall");

    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_payload_reg.last_word |-> m_payload_reg.frame_word == WORD_END)
        else $error("last flag on a word other than the end word");

    a_end_leaves_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        issue && kind == WK_END |=> state_reg == ST_IDLE)
        else $error("sequencer stayed in emission after end word");
`endif

endmodule

// File: bench/led_frame_word_checker.sv
// checker that predicts and compares the frame words of the led frame buffer serializer
`timescale 1ns / 1ps

module led_frame_word_checker import lfbs_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  s_payload_t s_payload,
    input  logic       m_valid,
    input  logic       m_ready,
    input  m_payload_t m_payload,
    output int         fail_count,
    output int         words_due,
    output int         words_checked
);

    logic [7:0] red_px   [LED_COUNT];
    logic [7:0] green_px [LED_COUNT];
    logic [7:0] blue_px  [LED_COUNT];

    m_payload_t frame_words_due [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("mismatch at %0t ns: %s, got %h, expected %h", $time, what, got, want);
    endtask

    task automatic blank_pixels();
        for (int i = 0; i < LED_COUNT; i++) begin
            red_px[i]   = 8'h00;
            green_px[i] = 8'h00;
            blue_px[i]  = 8'h00;
        end
    endtask

    // updates the pixel copy and queues the words an emit request will produce
    task automatic apply_request(input s_payload_t req);
        int slot;
        m_payload_t word;
        case (req.cmd)
            CMD_WRITE: begin
                // one-based index, clamped into the strip
                if (req.pixel_index == 8'd0) begin
                    slot = 0;
                end else if (int'(req.pixel_index) > LED_COUNT) begin
                    slot = LED_COUNT - 1;
                end else begin
                    slot = int'(req.pixel_index) - 1;
                end
                red_px[slot]   = req.red;
                green_px[slot] = req.green;
                blue_px[slot]  = req.blue;
            end
            CMD_CLEAR: begin
                blank_pixels();
            end
            CMD_EMIT: begin
                word.frame_word = WORD_START;
                word.last_word  = 1'b0;
                frame_words_due.push_back(word);
                for (int i = 0; i < LED_COUNT; i++) begin
                    word.frame_word = {FULL_BRIGHT, blue_px[i], green_px[i], red_px[i]};
                    word.last_word  = 1'b0;
                    frame_words_due.push_back(word);
                end
                word.frame_word = WORD_END;
                word.last_word  = 1'b1;
                frame_words_due.push_back(word);
            end
            default: begin
                // unused command leaves everything alone
            end
        endcase
    endtask

    always @(posedge aclk) begin
        m_payload_t want;
        if (!aresetn) begin
            blank_pixels();
            frame_words_due.delete();
            fail_count    = 0;
            words_checked = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_payload);
            end
            if (m_valid && m_ready) begin
                if (frame_words_due.size() == 0) begin
                    report_mismatch("word with nothing pending", m_payload.frame_word, '0);
                end else begin
                    want = frame_words_due.pop_front();
                    words_checked++;
                    if (m_payload.frame_word !== want.frame_word) begin
                        report_mismatch("frame_word", m_payload.frame_word, want.frame_word);
                    end
                    if (m_payload.last_word !== want.last_word) begin
                        report_mismatch("last_word", 32'(m_payload.last_word),
                                        32'(want.last_word));
                    end
                end
            end
        end
        words_due = frame_words_due.size();
    end

endmodule

// File: bench/led_frame_buffer_serializer_unit_tb.sv
// testbench top: request stimulus, result sink and verdict for the frame serializer
`timescale 1ns / 1ps

module led_frame_buffer_serializer_unit_tb;
    import lfbs_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 140;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    s_payload_t s_payload = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    m_payload_t m_payload;

    int fail_count;
    int words_due;
    int words_checked;

    bit idle_gaps = 1'b1;
    bit rx_hold_request = 1'b0;
    int writes_sent;
    int clears_sent;
    int emits_sent;
    int unused_sent;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    led_frame_buffer_serializer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    led_frame_word_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload     (m_payload),
        .fail_count    (fail_count),
        .words_due     (words_due),
        .words_checked (words_checked)
    );

    // offers one request and returns at the edge where it is taken
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] idx,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
        int gap;
        gap = idle_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{cmd, idx, r, g, b};
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        case (cmd)
            CMD_WRITE: writes_sent++;
            CMD_CLEAR: clears_sent++;
            CMD_EMIT:  emits_sent++;
            default:   unused_sent++;
        endcase
    endtask

    // mostly in-range pixels, with some zero and oversized indexes
    task automatic send_random_write();
        int pick;
        logic [7:0] idx;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            idx = 8'd0;
        end else if (pick == 1) begin
            idx = 8'($urandom_range(33, 255));
        end else begin
            idx = 8'($urandom_range(1, 32));
        end
        send_request(CMD_WRITE, idx, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_all_words();
        s_valid <= 1'b0;
        do @(negedge aclk); while (words_due != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // result sink: random stalls per word, one long hold-off on request
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = idle_gaps ? $urandom_range(0, 4) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_valid);
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        int pick;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // frame straight after reset shows an all-zero strip
        send_request(CMD_EMIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_WRITE, 8'd0, 8'hFF, 8'h00, 8'hA5);
        send_request(CMD_WRITE, 8'd32, 8'h00, 8'hFF, 8'h5A);
        send_request(CMD_WRITE, 8'd16, 8'h55, 8'hAA, 8'hFF);
        send_request(CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(CMD_WRITE, 8'd33, 8'hC3, 8'h3C, 8'h81);
        send_request(CMD_WRITE, 8'd2, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_EMIT, 8'h12, 8'h34, 8'h56, 8'h78);
        send_request(CMD_WRITE, 8'd255, 8'h7E, 8'h81, 8'h00);
        send_request(CMD_WRITE, 8'd31, 8'h00, 8'h00, 8'h00);
        send_request(CMD_EMIT, 8'hAA, 8'h55, 8'hAA, 8'h55);
        // unused command must neither write nor emit
        send_request(CMD_UNUSED, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_UNUSED, 8'd0, 8'h00, 8'h00, 8'h00);
        send_request(CMD_EMIT, 8'h01, 8'h02, 8'h03, 8'h04);
        // clear ignores its pixel fields
        send_request(CMD_CLEAR, 8'd5, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(CMD_WRITE, 8'd1, 8'h80, 8'h40, 8'h20);
        send_request(CMD_WRITE, 8'd17, 8'h01, 8'h02, 8'h04);
        send_request(CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(CMD_EMIT, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_request(CMD_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00);
        send_request(CMD_WRITE, 8'd0, 8'h3C, 8'hC3, 8'h99);
        send_request(CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);

        // pause until idle, then back up the output while requests pile in
        wait_all_words();
        rx_hold_request = 1'b1;
        send_request(CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (6) send_random_write();
        send_request(CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_all_words();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // a stretch with no idling on either side
            if (n == 60) idle_gaps = 1'b0;
            if (n == 100) idle_gaps = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_request(CMD_EMIT, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
            end else if (pick < 12) begin
                send_request(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
            end else if (pick < 15) begin
                send_request(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
            end else begin
                send_random_write();
            end
        end
        send_request(CMD_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_all_words();

        $display("covered %0d writes, %0d clears, %0d frame emits and %0d unused commands",
                 writes_sent, clears_sent, emits_sent, unused_sent);
        $display("checked %0d frame words, with random stalls and one long output hold-off",
                 words_checked);
        if (fail_count == 0 && words_due == 0) begin
            $display("led_frame_buffer_serializer_unit_tb passed");
        end else begin
            $display("led_frame_buffer_serializer_unit_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("led_frame_buffer_serializer_unit_tb failed");
        $finish;
    end

endmodule
